/* rtl/pnmhp_pkg.sv */
// Package for the PNM header parser: widths, character and status codes, phase enum and shared structs.
package pnmhp_pkg;

    localparam int DIM_BITS  = 16;
    localparam int LEN_BITS  = 32;
    localparam int AREA_BITS = 2 * DIM_BITS;
    localparam int NEED_BITS = AREA_BITS + 3;
    localparam int CMP_BITS  = (NEED_BITS > LEN_BITS) ? NEED_BITS : LEN_BITS;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_5     = 8'h35;
    localparam logic [7:0] CHAR_6     = 8'h36;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [DIM_BITS-1:0] BYTE_MAX = DIM_BITS'(255);

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_PARSE_ERR = 2'd1;
    localparam logic [1:0] STAT_SIZE_ERR  = 2'd2;

    localparam logic [1:0] PSIZE_ONE = 2'd1;
    localparam logic [1:0] PSIZE_TWO = 2'd2;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic [LEN_BITS-1:0] buffer_length;
        logic                first_byte;
    } pnm_in_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                image_type;
        logic [DIM_BITS-1:0] image_width;
        logic [DIM_BITS-1:0] image_height;
        logic [DIM_BITS-1:0] max_value;
        logic [1:0]          sample_bytes;
        logic [LEN_BITS-1:0] header_length;
    } pnm_out_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_MAGIC,
        PH_W_SKIP,
        PH_W_DIG,
        PH_H_SKIP,
        PH_H_DIG,
        PH_M_SKIP,
        PH_M_DIG,
        PH_AREA,
        PH_FINISH
    } phase_t;

    typedef struct packed {
        logic start;
        logic set_type;
        logic start_num;
        logic acc;
        logic store_w;
        logic store_h;
        logic count_inc;
        logic latch_hdr;
        logic calc_area;
        logic push_err;
        logic push_done;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic is_digit;
        logic is_space;
        logic is_p;
        logic is_5;
        logic is_6;
        logic overflow;
        logic idx_end;
        logic next_end;
        logic len_short;
    } stat_t;

endpackage

/* rtl/pnmhp_ctrl.sv */
// Parse controller: phase state machine issuing datapath commands per byte.
module pnmhp_ctrl
    import pnmhp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    phase_t state_reg;
    phase_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg == PH_AREA) || (state_reg == PH_FINISH);
        if (state_reg == PH_AREA)
        begin
            cmd.calc_area = 1'b1;
        end
        else if (state_reg == PH_FINISH)
        begin
            cmd.push_done = 1'b1;
        end
        else if (in_fire)
        begin
            if (stat.first)
            begin
                if (stat.len_short || !stat.is_p)
                begin
                    cmd.push_err = 1'b1;
                end
                else
                begin
                    cmd.start = 1'b1;
                end
            end
            else if (state_reg != PH_IDLE)
            begin
                if (stat.idx_end)
                begin
                    cmd.push_err = 1'b1;
                end
                else
                begin
                    unique case (state_reg)
                        PH_MAGIC:
                        begin
                            if (stat.is_5 || stat.is_6)
                            begin
                                cmd.set_type = 1'b1;
                            end
                            else
                            begin
                                cmd.push_err = 1'b1;
                            end
                        end
                        PH_W_SKIP, PH_H_SKIP, PH_M_SKIP:
                        begin
                            if (stat.is_digit)
                            begin
                                cmd.start_num = 1'b1;
                            end
                            else if (!stat.is_space)
                            begin
                                cmd.push_err = 1'b1;
                            end
                        end
                        PH_W_DIG, PH_H_DIG, PH_M_DIG:
                        begin
                            if (stat.is_digit)
                            begin
                                cmd.acc = 1'b1;
                            end
                            else if (stat.overflow)
                            begin
                                cmd.push_err = 1'b1;
                            end
                            else if (state_reg == PH_W_DIG)
                            begin
                                cmd.store_w = 1'b1;
                            end
                            else if (state_reg == PH_H_DIG)
                            begin
                                cmd.store_h  = 1'b1;
                                cmd.push_err = !stat.is_space;
                            end
                            else
                            begin
                                cmd.latch_hdr = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (!cmd.push_err && !cmd.latch_hdr)
                    begin
                        cmd.count_inc = 1'b1;
                        cmd.push_err  = stat.next_end;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PH_AREA:   state_next = PH_FINISH;
            PH_FINISH: state_next = PH_IDLE;
            default:
            begin
                if (in_fire)
                begin
                    priority if (cmd.push_err)
                    begin
                        state_next = PH_IDLE;
                    end
                    else if (cmd.start)
                    begin
                        state_next = PH_MAGIC;
                    end
                    else if (cmd.latch_hdr)
                    begin
                        state_next = PH_AREA;
                    end
                    else if (state_reg == PH_MAGIC)
                    begin
                        state_next = PH_W_SKIP;
                    end
                    else if (state_reg == PH_W_SKIP && stat.is_digit)
                    begin
                        state_next = PH_W_DIG;
                    end
                    else if (state_reg == PH_H_SKIP && stat.is_digit)
                    begin
                        state_next = PH_H_DIG;
                    end
                    else if (state_reg == PH_M_SKIP && stat.is_digit)
                    begin
                        state_next = PH_M_DIG;
                    end
                    else if (state_reg == PH_W_DIG && !stat.is_digit)
                    begin
                        state_next = PH_H_SKIP;
                    end
                    else if (state_reg == PH_H_DIG && !stat.is_digit)
                    begin
                        state_next = PH_M_SKIP;
                    end
                    else
                    begin
                        state_next = state_reg;
                    end
                end
            end
        endcase
    end

    a_no_request_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_fire)
        else $error("request accepted during payload check");

    a_area_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_AREA) |=> (state_reg == PH_FINISH))
        else $error("payload check sequence broken");

    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push_err && cmd.push_done))
        else $error("error and done result in the same cycle");

endmodule

/* rtl/pnmhp_datapath.sv */
// Datapath: field accumulators, byte counter, payload size check and result forming.
module pnmhp_datapath
    import pnmhp_pkg::*;
(
    input  logic     clk,
    input  pnm_in_t  byte_in,
    input  cmd_t     cmd,
    output stat_t    stat,
    output pnm_out_t res,
    output logic     res_valid
);

    logic [DIM_BITS-1:0]  accum_reg, accum_next;
    logic                 ovf_reg, ovf_next;
    logic [DIM_BITS-1:0]  width_reg;
    logic [DIM_BITS-1:0]  height_reg;
    logic                 type_reg;
    logic [LEN_BITS-1:0]  count_reg;
    logic [LEN_BITS-1:0]  length_reg;
    logic [LEN_BITS-1:0]  hdr_reg;
    logic [AREA_BITS-1:0] area_reg;
    logic [LEN_BITS-1:0]  remain_reg;

    logic [3:0]           digit;
    logic [DIM_BITS+3:0]  acc_sum;
    logic [LEN_BITS:0]    count_inc;
    logic                 psize_two;
    logic [NEED_BITS-1:0] area_ext;
    logic [NEED_BITS-1:0] area_ps;
    logic [NEED_BITS-1:0] need;
    logic                 too_big;

    assign digit     = byte_in.data_byte[3:0];
    assign count_inc = {1'b0, count_reg} + (LEN_BITS+1)'(1);

    assign stat.first     = byte_in.first_byte;
    assign stat.is_digit  = (byte_in.data_byte >= CHAR_0) && (byte_in.data_byte <= CHAR_9);
    assign stat.is_space  = (byte_in.data_byte == CHAR_SPACE)
                          || ((byte_in.data_byte >= CHAR_TAB) && (byte_in.data_byte <= CHAR_CR));
    assign stat.is_p      = (byte_in.data_byte == CHAR_P);
    assign stat.is_5      = (byte_in.data_byte == CHAR_5);
    assign stat.is_6      = (byte_in.data_byte == CHAR_6);
    assign stat.overflow  = ovf_reg;
    assign stat.idx_end   = (count_reg >= length_reg);
    assign stat.next_end  = (count_inc >= {1'b0, length_reg});
    assign stat.len_short = (byte_in.buffer_length < LEN_BITS'(2));

    // accum * 10 + digit
    assign acc_sum = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                   + (DIM_BITS+4)'(digit);

    always_comb
    begin
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        if (cmd.start)
        begin
            accum_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.start_num)
        begin
            accum_next = DIM_BITS'(digit);
            ovf_next   = 1'b0;
        end
        else if (cmd.acc && !ovf_reg)
        begin
            if (acc_sum[DIM_BITS+3:DIM_BITS] != 4'd0)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                accum_next = acc_sum[DIM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        accum_reg <= accum_next;
        ovf_reg   <= ovf_next;
        if (cmd.start)
        begin
            length_reg <= byte_in.buffer_length;
            count_reg  <= LEN_BITS'(1);
            type_reg   <= 1'b0;
        end
        else if (cmd.count_inc)
        begin
            count_reg <= count_inc[LEN_BITS-1:0];
        end
        if (cmd.set_type)
        begin
            type_reg <= stat.is_6;
        end
        if (cmd.store_w)
        begin
            width_reg <= accum_reg;
        end
        if (cmd.store_h)
        begin
            height_reg <= accum_reg;
        end
        if (cmd.latch_hdr)
        begin
            hdr_reg <= count_inc[LEN_BITS-1:0];
        end
        if (cmd.calc_area)
        begin
            area_reg   <= width_reg * height_reg;
            remain_reg <= (length_reg >= hdr_reg) ? (length_reg - hdr_reg) : '0;
        end
    end

    assign psize_two = (accum_reg > BYTE_MAX);
    assign area_ext  = NEED_BITS'(area_reg);
    assign area_ps   = psize_two ? (area_ext << 1) : area_ext;
    assign need      = type_reg ? (area_ps + (area_ps << 1)) : area_ps;
    assign too_big   = CMP_BITS'(need) > CMP_BITS'(remain_reg);

    always_comb
    begin
        res = '0;
        if (cmd.push_err)
        begin
            res.status = STAT_PARSE_ERR;
        end
        else
        begin
            res.status        = too_big ? STAT_SIZE_ERR : STAT_OK;
            res.image_type    = type_reg;
            res.image_width   = width_reg;
            res.image_height  = height_reg;
            res.max_value     = accum_reg;
            res.sample_bytes  = psize_two ? PSIZE_TWO : PSIZE_ONE;
            res.header_length = hdr_reg;
        end
    end

    assign res_valid = cmd.push_err || cmd.push_done;

endmodule

/* rtl/pnmhp_outq.sv */
// Two-entry result queue between the parser and the header output channel.
module pnmhp_outq
    import pnmhp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pnm_out_t push_data,
    output logic     full,
    output logic     out_valid,
    input  logic     out_ready,
    output pnm_out_t out_data
);

    logic [1:0] count_reg, count_next;
    pnm_out_t   q0_reg, q0_next;
    pnm_out_t   q1_reg, q1_next;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && out_ready;
    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = q0_reg;

    always_comb
    begin
        count_next = count_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        priority if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                q0_next = push_data;
            end
            else
            begin
                q0_next = q1_reg;
                q1_next = push_data;
            end
        end
        else if (pop)
        begin
            q0_next    = q1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                q0_next = push_data;
            end
            else
            begin
                q1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> out_ready)
        else $error("result queue overrun");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

/* rtl/pnm_header_parser.sv */
// Top level of the PNM P5/P6 header parser.
//
//  channel  | dir | payload     | handshake
//  byte     | in  | pnm_in_t    | byte_valid / byte_ready
//  header   | out | pnm_out_t   | header_valid / header_ready
//
// One byte per cycle while parsing. The byte ending max color starts a
// payload check (16x16 area multiply, then scale and compare), byte_ready low.
// Results go through a 2-entry queue; byte_ready also drops while it is full.
// Reset puts the parser idle; bytes without first_byte are dropped until one with it.
module pnm_header_parser
    import pnmhp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  pnm_in_t  byte_data,
    output logic     header_valid,
    input  logic     header_ready,
    output pnm_out_t header_data
);

    cmd_t     cmd;
    stat_t    stat;
    logic     busy;
    logic     q_full;
    logic     in_fire;
    pnm_out_t res;
    logic     res_valid;

    assign byte_ready = !busy && !q_full;
    assign in_fire    = byte_valid && byte_ready;

    pnmhp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    pnmhp_datapath u_dp (
        .clk       (clk),
        .byte_in   (byte_data),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res),
        .res_valid (res_valid)
    );

    pnmhp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (q_full),
        .out_valid (header_valid),
        .out_ready (header_ready),
        .out_data  (header_data)
    );

endmodule
